FILE: sv/amof_pkg.sv
package amof_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [3:0] MODE_IMP = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_ZP  = 4'd2;
  localparam logic [3:0] MODE_ZPX = 4'd3;
  localparam logic [3:0] MODE_ZPY = 4'd4;
  localparam logic [3:0] MODE_IZX = 4'd5;
  localparam logic [3:0] MODE_IZY = 4'd6;
  localparam logic [3:0] MODE_ABS = 4'd7;
  localparam logic [3:0] MODE_ABX = 4'd8;
  localparam logic [3:0] MODE_ABY = 4'd9;
  localparam logic [3:0] MODE_IND = 4'd10;
  localparam logic [3:0] MODE_REL = 4'd11;

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;
  localparam logic [2:0] STEP_5    = 3'd5;

  localparam logic [7:0]  PAGE_END  = 8'hff;
  localparam logic [15:0] PAGE_MASK = 16'hff00;

  typedef struct packed {
    logic [3:0]  mode;
    logic [2:0]  step;
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] pointer;
    logic [7:0]  low_byte;
  } fetch_state_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  mode;
    logic [15:0] pc_in;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [15:0] read_address;
    logic [7:0]  operand;
    logic [15:0] next_pc;
  } result_t;

  function automatic logic [2:0] last_step(input logic [3:0] m);
    logic [2:0] s;
    unique case (m)
      MODE_IMM, MODE_REL:           s = STEP_1;
      MODE_ZP, MODE_ZPX, MODE_ZPY:  s = STEP_2;
      MODE_ABS, MODE_ABX, MODE_ABY: s = STEP_3;
      MODE_IZX, MODE_IZY:           s = STEP_4;
      MODE_IND:                     s = STEP_5;
      default:                      s = STEP_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] op_length(input logic [3:0] m);
    return (m >= MODE_ABS && m <= MODE_IND) ? 2'd2 : 2'd1;
  endfunction

endpackage

FILE: sv/addressing_mode_operand_fetch_unit.sv
// the result of an accepted item passes the input register and then the result register,
// where it is held until the output takes it
// throughput: one item per cycle while the output is not stalled, requests and returned data alike
// a data item while idle is consumed with no result
// reset (rst_n low, synchronous) empties both registers and clears the fetch state to idle
module addressing_mode_operand_fetch_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[3:0], pc_in[19:4], x_index[27:20], y_index[35:28],
                                  // read_data[43:36], zero fill
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_address[15:0], operand[23:16], next_pc[39:24]
  output logic        out_tuser   // kind
);
  import amof_pkg::*;

  logic         in_valid_r;
  in_item_t     in_r;
  fetch_state_t st_r;
  fetch_state_t st_nxt;
  result_t      res;
  logic         out_valid_r;
  result_t      out_r;
  logic         process;

  assign process   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r.op        <= in_tuser;
      in_r.mode      <= in_tdata[3:0];
      in_r.pc_in     <= in_tdata[19:4];
      in_r.x_index   <= in_tdata[27:20];
      in_r.y_index   <= in_tdata[35:28];
      in_r.read_data <= in_tdata[43:36];
    end
  end

  amof_step u_step (
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (process) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (process && res.vld) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && res.vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {out_r.next_pc, out_r.operand, out_r.read_address};

endmodule

FILE: sv/amof_step.sv
module amof_step (
  input  amof_pkg::fetch_state_t st,
  input  amof_pkg::in_item_t     item,
  output amof_pkg::fetch_state_t st_nxt,
  output amof_pkg::result_t      res
);
  import amof_pkg::*;

  logic [7:0]  d;
  logic [15:0] word;
  logic [15:0] addr;
  logic [2:0]  ls_start;
  logic [2:0]  ls_cur;

  assign d        = item.read_data;
  assign word     = {d, st.low_byte};
  assign ls_start = last_step(item.mode);
  assign ls_cur   = last_step(st.mode);

  always_comb begin
    st_nxt = st;
    res    = '0;
    addr   = '0;
    if (item.op == OP_START) begin
      st_nxt.mode     = item.mode;
      st_nxt.pc       = item.pc_in;
      st_nxt.x        = item.x_index;
      st_nxt.y        = item.y_index;
      st_nxt.pointer  = '0;
      st_nxt.low_byte = '0;
      res.vld = 1'b1;
      if (ls_start == STEP_IDLE) begin
        // implied and unknown modes finish at once
        st_nxt.step = STEP_IDLE;
        res.kind    = KIND_DONE;
        res.next_pc = item.pc_in;
      end else begin
        st_nxt.step      = STEP_1;
        res.kind         = KIND_REQ;
        res.read_address = item.pc_in;
      end
    end else if (st.step != STEP_IDLE) begin
      res.vld = 1'b1;
      if (st.step >= ls_cur) begin
        st_nxt.step = STEP_IDLE;
        res.kind    = KIND_DONE;
        res.operand = d;
        res.next_pc = st.pc + {14'd0, op_length(st.mode)};
      end else begin
        unique case (st.step)
          STEP_1: begin
            unique case (st.mode)
              MODE_ZP:  addr = {8'd0, d};
              MODE_ZPX: addr = {8'd0, d + st.x};
              MODE_ZPY: addr = {8'd0, d + st.y};
              MODE_IZX: begin
                st_nxt.pointer = {8'd0, d + st.x};
                addr = {8'd0, d + st.x};
              end
              MODE_IZY: begin
                st_nxt.pointer = {8'd0, d};
                addr = {8'd0, d};
              end
              default: begin
                st_nxt.low_byte = d;
                addr = st.pc + 16'd1;
              end
            endcase
          end
          STEP_2: begin
            unique case (st.mode)
              MODE_IZX, MODE_IZY: begin
                st_nxt.low_byte = d;
                addr = {8'd0, st.pointer[7:0] + 8'd1};
              end
              MODE_ABX: addr = word + {8'd0, st.x};
              MODE_ABY: addr = word + {8'd0, st.y};
              MODE_IND: begin
                st_nxt.pointer = word;
                addr = word;
              end
              default: addr = word;
            endcase
          end
          STEP_3: begin
            unique case (st.mode)
              MODE_IZY: addr = word + {8'd0, st.y};
              MODE_IND: begin
                st_nxt.low_byte = d;
                // pointer at page end wraps to the start of the same page
                addr = (st.pointer[7:0] == PAGE_END) ? (st.pointer & PAGE_MASK)
                                                     : (st.pointer + 16'd1);
              end
              default: addr = word;
            endcase
          end
          default: addr = word;
        endcase
        st_nxt.step      = st.step + 3'd1;
        res.kind         = KIND_REQ;
        res.read_address = addr;
      end
    end
  end

endmodule
